// ===== src/wstd_pkg.sv =====
// Shared constants, codes and types of the work-stealing task dispatch block.
package wstd_pkg;

  // Sizes of the queue store. Both must stay powers of two: a store address is
  // the queue index concatenated with the slot index.
  localparam int MAX_WORKERS = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int TASK_BITS   = 16;

  // Derived widths.
  localparam int W_W      = $clog2(MAX_WORKERS);       // worker index
  localparam int WC_W     = 4;                         // worker_count register
  localparam int THR_W    = 5;                         // steal_threshold register
  localparam int QA_W     = $clog2(QUEUE_DEPTH);       // slot index inside a queue
  localparam int QC_W     = $clog2(QUEUE_DEPTH + 1);   // queue occupancy
  localparam int RAM_DEPTH = MAX_WORKERS * QUEUE_DEPTH;
  localparam int RAM_AW   = W_W + QA_W;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = ((TASK_BITS + W_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TASK_BITS + W_W + 7) / 8) * 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_USER_W = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEAL_THRESHOLD = 1'd1;

  // Register reset values and limits.
  localparam logic [WC_W-1:0]  WORKER_COUNT_RESET = 4'd8;
  localparam logic [THR_W-1:0] THRESHOLD_RESET    = 5'd4;
  localparam logic [THR_W-1:0] MIN_THRESHOLD      = 5'd2;

  // Request opcodes.
  localparam logic OP_SUBMIT  = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // One accepted request together with the effective configuration.
  typedef struct packed {
    logic                 op;
    logic [TASK_BITS-1:0] task_id;
    logic [W_W-1:0]       worker;
    logic [WC_W-1:0]      wc;
    logic [THR_W-1:0]     thr;
  } req_t;

  // One result.
  typedef struct packed {
    logic                 got_task;
    logic [TASK_BITS-1:0] task_out;
    logic                 was_stolen;
    logic [W_W-1:0]       target_worker;
    logic                 dropped;
  } res_t;

endpackage

// ===== src/wstd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wstd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/wstd_ctrl.sv =====
// Sequencer of the dispatch block: queue pointers, victim scan and task moves.
module wstd_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  wstd_pkg::req_t                 item,
  output logic                           idle,
  output logic                           res_valid,
  input  logic                           res_ready,
  output wstd_pkg::res_t                 res,
  output logic                           ram_we,
  output logic [wstd_pkg::RAM_AW-1:0]    ram_waddr,
  output logic [wstd_pkg::TASK_BITS-1:0] ram_wdata,
  output logic                           ram_re,
  output logic [wstd_pkg::RAM_AW-1:0]    ram_raddr,
  input  logic [wstd_pkg::TASK_BITS-1:0] ram_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  wstd_pkg::req_t               item_r, item_nxt;
  wstd_pkg::res_t               res_r, res_nxt;
  logic [wstd_pkg::W_W-1:0]     rr_r, rr_nxt;
  logic [wstd_pkg::QA_W-1:0]    head_r [wstd_pkg::MAX_WORKERS];
  logic [wstd_pkg::QA_W-1:0]    head_nxt [wstd_pkg::MAX_WORKERS];
  logic [wstd_pkg::QC_W-1:0]    count_r [wstd_pkg::MAX_WORKERS];
  logic [wstd_pkg::QC_W-1:0]    count_nxt [wstd_pkg::MAX_WORKERS];
  logic [wstd_pkg::WC_W-1:0]    k_r, k_nxt;
  logic [wstd_pkg::W_W-1:0]     v_r, v_nxt;
  logic [wstd_pkg::W_W-1:0]     victim_r, victim_nxt;
  logic [wstd_pkg::QC_W-1:0]    pops_r, pops_nxt;
  logic [wstd_pkg::QA_W-1:0]    widx_r, widx_nxt;
  logic                         first_r, first_nxt;
  logic                         pend_r, pend_nxt;
  logic                         pend_first_r, pend_first_nxt;

  logic [wstd_pkg::W_W-1:0]     cur_q;
  logic [wstd_pkg::QA_W-1:0]    head_cur;
  logic [wstd_pkg::QC_W-1:0]    cnt_cur;
  logic [wstd_pkg::W_W-1:0]     sel;
  logic [wstd_pkg::WC_W-1:0]    rr_inc;
  logic [wstd_pkg::WC_W-1:0]    req_inc;
  logic [wstd_pkg::WC_W-1:0]    v_inc;
  logic                         req_ok;
  logic                         victim_ok;

  // The one pointer/occupancy read port, steered by the sequencer.
  assign head_cur = head_r[cur_q];
  assign cnt_cur  = count_r[cur_q];

  // Round-robin choice and the wrapped successors used by submit and scan.
  assign sel     = ({1'b0, rr_r} < item_r.wc) ? rr_r : '0;
  assign rr_inc  = {1'b0, sel} + 1'b1;
  assign req_inc = {1'b0, item_r.worker} + 1'b1;
  assign v_inc   = {1'b0, v_r} + 1'b1;
  assign req_ok  = ({1'b0, item_r.worker} < item_r.wc);
  assign victim_ok = ({{wstd_pkg::THR_W{1'b0}}, cnt_cur} >=
                      {{wstd_pkg::QC_W{1'b0}}, item_r.thr});

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    res_nxt        = res_r;
    rr_nxt         = rr_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    v_nxt          = v_r;
    victim_nxt     = victim_r;
    pops_nxt       = pops_r;
    widx_nxt       = widx_r;
    first_nxt      = first_r;
    pend_nxt       = pend_r;
    pend_first_nxt = pend_first_r;
    cur_q          = item_r.worker;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = item_r.task_id;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = item;
          res_nxt   = '0;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        if (item_r.op == wstd_pkg::OP_SUBMIT) begin
          // Submit: append at the newest end of the round-robin queue.
          cur_q = sel;
          rr_nxt = (rr_inc >= item_r.wc) ? '0 : rr_inc[wstd_pkg::W_W-1:0];
          res_nxt.target_worker = sel;
          if (cnt_cur >= wstd_pkg::QC_W'(wstd_pkg::QUEUE_DEPTH)) begin
            res_nxt.dropped = 1'b1;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = {sel, head_cur + cnt_cur[wstd_pkg::QA_W-1:0]};
            count_nxt[sel] = cnt_cur + 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          // Request: own queue first, otherwise start the victim scan.
          cur_q = item_r.worker;
          if (!req_ok) begin
            state_nxt = S_DONE;
          end else if (cnt_cur != '0) begin
            victim_nxt            = item_r.worker;
            pops_nxt              = wstd_pkg::QC_W'(1);
            first_nxt             = 1'b1;
            res_nxt.got_task      = 1'b1;
            res_nxt.target_worker = item_r.worker;
            state_nxt             = S_MOVE;
          end else begin
            k_nxt     = wstd_pkg::WC_W'(1);
            v_nxt     = (req_inc >= item_r.wc) ? '0 : req_inc[wstd_pkg::W_W-1:0];
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // One candidate victim per cycle against the threshold.
        cur_q = v_r;
        if (k_r >= item_r.wc) begin
          state_nxt = S_DONE;
        end else if (victim_ok) begin
          victim_nxt                = v_r;
          pops_nxt                  = cnt_cur >> 1;
          first_nxt                 = 1'b1;
          widx_nxt                  = '0;
          head_nxt[item_r.worker]   = '0;
          count_nxt[item_r.worker]  = '0;
          res_nxt.got_task          = 1'b1;
          res_nxt.was_stolen        = 1'b1;
          res_nxt.target_worker     = v_r;
          state_nxt                 = S_MOVE;
        end else begin
          k_nxt = k_r + 1'b1;
          v_nxt = (v_inc >= item_r.wc) ? '0 : v_inc[wstd_pkg::W_W-1:0];
        end
      end

      S_MOVE: begin
        // Pop the victim's oldest entries, one read a cycle; the first one is
        // handed out, the rest land in the requester's queue in the cycle after their read.
        cur_q = victim_r;
        if (pops_r != '0) begin
          ram_re               = 1'b1;
          ram_raddr            = {victim_r, head_cur};
          head_nxt[victim_r]   = head_cur + 1'b1;
          count_nxt[victim_r]  = cnt_cur - 1'b1;
          pops_nxt             = pops_r - 1'b1;
          pend_nxt             = 1'b1;
          pend_first_nxt       = first_r;
          first_nxt            = 1'b0;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (pend_first_r) begin
            res_nxt.task_out = ram_rdata;
          end else begin
            ram_we                   = 1'b1;
            ram_waddr                = {item_r.worker, widx_r};
            ram_wdata                = ram_rdata;
            widx_nxt                 = widx_r + 1'b1;
            count_nxt[item_r.worker] = wstd_pkg::QC_W'(widx_r) + 1'b1;
          end
        end
        if (pops_r == '0 && !pend_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rr_r    <= '0;
      pend_r  <= 1'b0;
      for (int i = 0; i < wstd_pkg::MAX_WORKERS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rr_r    <= rr_nxt;
      pend_r  <= pend_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    res_r        <= res_nxt;
    k_r          <= k_nxt;
    v_r          <= v_nxt;
    victim_r     <= victim_nxt;
    pops_r       <= pops_nxt;
    widx_r       <= widx_nxt;
    first_r      <= first_nxt;
    pend_first_r <= pend_first_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

// ===== src/work_stealing_task_dispatch.sv =====
// Top level of the work-stealing task dispatch block.
//
// Eight bounded task queues of sixteen entries share one task store; a
// sequencer with a single occupancy read port and a single store read port
// serves one request at a time and holds in_tready low meanwhile. A submit,
// or a request from a worker beyond worker_count, passes through decode to
// completion; a request served from the worker's own queue also pops one
// entry on the way. A request that must steal scans the other workers in turn
// (up to worker_count - 1) and then pops the victim's older half of n entries
// through the store's registered read port, one entry a cycle. A scan that
// finds no victim ends in the cycle after its last candidate. The longest
// request is a steal of eight entries from the seventh candidate. in_tready
// rises again together with a result entering the output register, so the
// next request is accepted while a finished result still waits for
// out_tready; a second result waits inside the sequencer until the first one
// is taken. The task store needs no clearing after reset.
module work_stealing_task_dispatch (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream. tdata: task_id, worker. tuser: opcode.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wstd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [wstd_pkg::IN_USER_W-1:0]  in_tuser,
  // Result stream. tdata: task_out, target_worker.
  // tuser: got_task, was_stolen, dropped.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wstd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [wstd_pkg::OUT_USER_W-1:0] out_tuser,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wstd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wstd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [wstd_pkg::WC_W-1:0]      wc_cfg_r;
  logic [wstd_pkg::THR_W-1:0]     thr_cfg_r;
  logic [wstd_pkg::WC_W-1:0]      wc_eff;
  logic [wstd_pkg::THR_W-1:0]     thr_eff;
  wstd_pkg::req_t                 item;
  wstd_pkg::res_t                 res;
  wstd_pkg::res_t                 out_res_r;
  logic                           out_valid_r, out_valid_nxt;
  logic                           ctrl_idle;
  logic                           res_valid;
  logic                           res_ready;
  logic                           start;
  logic                           ram_we;
  logic [wstd_pkg::RAM_AW-1:0]    ram_waddr;
  logic [wstd_pkg::TASK_BITS-1:0] ram_wdata;
  logic                           ram_re;
  logic [wstd_pkg::RAM_AW-1:0]    ram_raddr;
  logic [wstd_pkg::TASK_BITS-1:0] ram_rdata;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_cfg_r  <= wstd_pkg::WORKER_COUNT_RESET;
      thr_cfg_r <= wstd_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wstd_pkg::REG_WORKER_COUNT:    wc_cfg_r  <= cfg_data[wstd_pkg::WC_W-1:0];
        wstd_pkg::REG_STEAL_THRESHOLD: thr_cfg_r <= cfg_data[wstd_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective worker count and threshold after clamping.
  always_comb begin
    priority if (wc_cfg_r == '0) begin
      wc_eff = wstd_pkg::WC_W'(1);
    end else if (wc_cfg_r > wstd_pkg::WC_W'(wstd_pkg::MAX_WORKERS)) begin
      wc_eff = wstd_pkg::WC_W'(wstd_pkg::MAX_WORKERS);
    end else begin
      wc_eff = wc_cfg_r;
    end
  end

  assign thr_eff = (thr_cfg_r < wstd_pkg::MIN_THRESHOLD) ? wstd_pkg::MIN_THRESHOLD : thr_cfg_r;

  // Unpack the input request.
  assign item.op      = in_tuser[0];
  assign item.task_id = in_tdata[wstd_pkg::TASK_BITS-1:0];
  assign item.worker  = in_tdata[wstd_pkg::TASK_BITS +: wstd_pkg::W_W];
  assign item.wc      = wc_eff;
  assign item.thr     = thr_eff;

  assign in_tready = ctrl_idle;
  assign start     = in_tvalid && in_tready;

  wstd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .idle      (ctrl_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  wstd_ram #(
    .WIDTH (wstd_pkg::TASK_BITS),
    .DEPTH (wstd_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: loads when empty or when its result is being taken.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  // Pack the result.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = wstd_pkg::OUT_DATA_W'({out_res_r.target_worker, out_res_r.task_out});
  assign out_tuser  = {out_res_r.dropped, out_res_r.was_stolen, out_res_r.got_task};

endmodule

// ===== src/wstd_checker.sv =====
// Port-level assertions for the dispatch block, bound to its top level.
module wstd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wstd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [wstd_pkg::OUT_USER_W-1:0] out_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // After an accepted request, the sequencer holds in_tready low in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready again right after an accepted request");

  // A steal always hands out a task.
  a_stolen_has_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("stolen flag without a task");

  // A result without a task carries no stolen flag and a zero identifier.
  a_drop_no_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tuser[1] &&
      (out_tdata[wstd_pkg::TASK_BITS-1:0] == '0))
    else $error("task fields set on a result without a task");

  // A dropped submit never reports a task.
  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0])
    else $error("dropped submit reports a task");

endmodule

bind work_stealing_task_dispatch wstd_checker u_wstd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the work-stealing task dispatch block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int BLOCK_ITEMS = 50;

  // Mirror of the task queues: predicts one result per accepted request and checks it.
  class queue_mirror;
    int unsigned worker_count;
    int unsigned steal_threshold;
    int unsigned rr_next;
    logic [wstd_pkg::TASK_BITS-1:0] slots [wstd_pkg::MAX_WORKERS][wstd_pkg::QUEUE_DEPTH];
    int unsigned heads [wstd_pkg::MAX_WORKERS];
    int unsigned counts [wstd_pkg::MAX_WORKERS];
    wstd_pkg::res_t awaited_results [$];
    int errors;

    function new();
      worker_count = wstd_pkg::WORKER_COUNT_RESET;
      steal_threshold = wstd_pkg::THRESHOLD_RESET;
      rr_next = 0;
      errors = 0;
      foreach (heads[i]) begin
        heads[i] = 0;
        counts[i] = 0;
      end
    endfunction

    function void write_reg(logic [wstd_pkg::CFG_IDX_W-1:0] idx,
                            logic [wstd_pkg::CFG_DATA_W-1:0] value);
      if (idx == wstd_pkg::REG_WORKER_COUNT) begin
        worker_count = value[wstd_pkg::WC_W-1:0];
      end else begin
        steal_threshold = value[wstd_pkg::THR_W-1:0];
      end
    endfunction

    function logic [wstd_pkg::TASK_BITS-1:0] take_oldest(int unsigned q);
      logic [wstd_pkg::TASK_BITS-1:0] v;
      v = slots[q][heads[q]];
      heads[q] = (heads[q] + 1) % wstd_pkg::QUEUE_DEPTH;
      counts[q] = counts[q] - 1;
      return v;
    endfunction

    function void note_request(logic op, logic [wstd_pkg::TASK_BITS-1:0] task_id,
                               logic [wstd_pkg::W_W-1:0] worker);
      int unsigned wc;
      int unsigned thr;
      int unsigned sel;
      int unsigned req;
      int unsigned v;
      int unsigned n;
      wstd_pkg::res_t r;
      r = '0;
      // Out-of-range worker counts are clamped to 1..MAX_WORKERS.
      wc = worker_count;
      if (wc < 1) wc = 1;
      if (wc > wstd_pkg::MAX_WORKERS) wc = wstd_pkg::MAX_WORKERS;
      if (op == wstd_pkg::OP_SUBMIT) begin
        // A pointer left beyond the worker count sends the task to queue 0.
        sel = (rr_next < wc) ? rr_next : 0;
        rr_next = (sel + 1 >= wc) ? 0 : sel + 1;
        r.target_worker = wstd_pkg::W_W'(sel);
        if (counts[sel] >= wstd_pkg::QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          slots[sel][(heads[sel] + counts[sel]) % wstd_pkg::QUEUE_DEPTH] = task_id;
          counts[sel] = counts[sel] + 1;
        end
      end else begin
        req = worker;
        if (req < wc) begin
          if (counts[req] > 0) begin
            r.got_task = 1'b1;
            r.task_out = take_oldest(req);
            r.target_worker = wstd_pkg::W_W'(req);
          end else begin
            // Scan the other workers, starting after the requester.
            thr = (steal_threshold < wstd_pkg::MIN_THRESHOLD) ?
                  wstd_pkg::MIN_THRESHOLD : steal_threshold;
            for (int k = 1; k < wc && !r.got_task; k++) begin
              v = (req + k) % wc;
              if (counts[v] >= thr) begin
                n = counts[v] / 2;
                r.got_task = 1'b1;
                r.was_stolen = 1'b1;
                r.target_worker = wstd_pkg::W_W'(v);
                r.task_out = take_oldest(v);
                heads[req] = 0;
                counts[req] = 0;
                for (int i = 1; i < n; i++) begin
                  slots[req][counts[req]] = take_oldest(v);
                  counts[req] = counts[req] + 1;
                end
              end
            end
          end
        end
      end
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [wstd_pkg::OUT_DATA_W-1:0] tdata,
                               logic [wstd_pkg::OUT_USER_W-1:0] tuser);
      wstd_pkg::res_t seen;
      wstd_pkg::res_t want;
      seen.task_out = tdata[wstd_pkg::TASK_BITS-1:0];
      seen.target_worker = tdata[wstd_pkg::TASK_BITS +: wstd_pkg::W_W];
      seen.got_task = tuser[0];
      seen.was_stolen = tuser[1];
      seen.dropped = tuser[2];
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result got=%0d task=%h stolen=%0d target=%0d dropped=%0d",
                 $time, seen.got_task, seen.task_out, seen.was_stolen,
                 seen.target_worker, seen.dropped);
        return;
      end
      want = awaited_results.pop_front();
      if (seen !== want) begin
        errors++;
        $display("%0t: expected got=%0d task=%h stolen=%0d target=%0d dropped=%0d,",
                 $time, want.got_task, want.task_out, want.was_stolen,
                 want.target_worker, want.dropped,
                 " actual got=%0d task=%h stolen=%0d target=%0d dropped=%0d",
                 seen.got_task, seen.task_out, seen.was_stolen,
                 seen.target_worker, seen.dropped);
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [wstd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [wstd_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [wstd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [wstd_pkg::OUT_USER_W-1:0] out_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [wstd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wstd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 18;
  int recv_idle_pct = 45;
  int cycle_count = 0;
  int wc_choices [10] = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 15};
  int thr_choices [11] = '{0, 1, 2, 3, 4, 6, 8, 12, 16, 17, 31};

  queue_mirror mirror = new();

  work_stealing_task_dispatch u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.check_result(out_tdata, out_tuser);
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("work_stealing_task_dispatch: mismatch");
      $finish;
    end
  end

  // Present one request and hold it until accepted; an idle gap may follow.
  // When no gap follows, in_tvalid stays high for the next request.
  task automatic push_request(input logic op,
                              input logic [wstd_pkg::TASK_BITS-1:0] task_id,
                              input logic [wstd_pkg::W_W-1:0] worker);
    int gap;
    gap = 0;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {{(wstd_pkg::IN_DATA_W-wstd_pkg::TASK_BITS-wstd_pkg::W_W){1'b0}},
                 worker, task_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.note_request(op, task_id, worker);
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wstd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wstd_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror.write_reg(idx, value);
  endtask

  // Write both registers back to back; only called while the block is idle.
  task automatic configure(input int wc, input int thr);
    write_reg(wstd_pkg::REG_WORKER_COUNT, wc[wstd_pkg::CFG_DATA_W-1:0]);
    write_reg(wstd_pkg::REG_STEAL_THRESHOLD, thr[wstd_pkg::CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  // One block of random traffic: submit bursts, repeated requests from one
  // worker to empty its queue and force steals, and scattered noise.
  task automatic random_block(input int quota);
    int issued;
    int kind;
    int len;
    logic [wstd_pkg::W_W-1:0] wkr;
    issued = 0;
    while (issued < quota) begin
      kind = $urandom_range(9);
      wkr = wstd_pkg::W_W'($urandom_range(wstd_pkg::MAX_WORKERS - 1));
      if (kind <= 3) begin
        len = $urandom_range(24, 1);
        repeat (len) push_request(wstd_pkg::OP_SUBMIT, wstd_pkg::TASK_BITS'($urandom),
                                  wstd_pkg::W_W'($urandom_range(wstd_pkg::MAX_WORKERS - 1)));
      end else if (kind <= 6) begin
        len = $urandom_range(10, 1);
        repeat (len) push_request(wstd_pkg::OP_REQUEST, wstd_pkg::TASK_BITS'($urandom), wkr);
      end else if (kind <= 8) begin
        len = $urandom_range(8, 1);
        repeat (len) push_request(wstd_pkg::OP_REQUEST, wstd_pkg::TASK_BITS'($urandom),
                                  wstd_pkg::W_W'($urandom_range(wstd_pkg::MAX_WORKERS - 1)));
      end else begin
        len = 1;
        push_request($urandom_range(1) ? wstd_pkg::OP_REQUEST : wstd_pkg::OP_SUBMIT,
                     wstd_pkg::TASK_BITS'($urandom),
                     wstd_pkg::W_W'($urandom_range(wstd_pkg::MAX_WORKERS - 1)));
      end
      issued += len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: two workers, lowest threshold.
    configure(2, 2);
    push_request(wstd_pkg::OP_REQUEST, 16'h0123, 3'd0);   // all queues empty
    push_request(wstd_pkg::OP_REQUEST, 16'hFFFF, 3'd7);   // requester beyond worker count
    push_request(wstd_pkg::OP_SUBMIT, 16'hFFFF, 3'd7);
    push_request(wstd_pkg::OP_SUBMIT, 16'h0000, 3'd0);
    push_request(wstd_pkg::OP_SUBMIT, 16'h8001, 3'd5);
    push_request(wstd_pkg::OP_SUBMIT, 16'h7FFE, 3'd2);
    push_request(wstd_pkg::OP_SUBMIT, 16'h1111, 3'd1);
    push_request(wstd_pkg::OP_SUBMIT, 16'h2222, 3'd3);
    push_request(wstd_pkg::OP_SUBMIT, 16'h3333, 3'd6);
    push_request(wstd_pkg::OP_REQUEST, 16'h0000, 3'd1);   // own queue, oldest first
    push_request(wstd_pkg::OP_REQUEST, 16'hFFFF, 3'd1);
    push_request(wstd_pkg::OP_REQUEST, 16'h5555, 3'd1);
    push_request(wstd_pkg::OP_REQUEST, 16'hAAAA, 3'd1);   // own queue empty: steal half of queue 0
    push_request(wstd_pkg::OP_REQUEST, 16'h0000, 3'd1);   // task moved by the steal
    push_request(wstd_pkg::OP_REQUEST, 16'h0000, 3'd0);
    push_request(wstd_pkg::OP_REQUEST, 16'h0000, 3'd0);
    push_request(wstd_pkg::OP_REQUEST, 16'h0000, 3'd0);   // nothing left anywhere
    drain();

    // Worker count zero acts as one; threshold one acts as two; the pointer
    // left at one now lies beyond the worker count.
    configure(0, 1);
    push_request(wstd_pkg::OP_SUBMIT, 16'hBEEF, 3'd4);
    push_request(wstd_pkg::OP_REQUEST, 16'h0000, 3'd1);
    push_request(wstd_pkg::OP_REQUEST, 16'h0000, 3'd0);
    drain();

    // Random traffic in three idling phases, with a new setting per block.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 18 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        if (blk == 0) begin
          configure((phase == 0) ? 1 : (phase == 1) ? 8 : 15,
                    (phase == 0) ? 16 : (phase == 1) ? 0 : 31);
        end else begin
          configure(wc_choices[$urandom_range(9)], thr_choices[$urandom_range(10)]);
        end
        random_block(BLOCK_ITEMS);
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("work_stealing_task_dispatch: match");
    end else begin
      $display("work_stealing_task_dispatch: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wstd_pkg.sv
src/wstd_ram.sv
src/wstd_ctrl.sv
src/work_stealing_task_dispatch.sv
src/wstd_checker.sv
sim/tb_top.sv
